// File: rtl/char_lcd_nibble_write_sequencer_assert.svh
// Assertion macros for the display sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CLNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");
// next-cycle implication
`define CLNS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");
`else
`define CLNS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLNS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/clns_pkg.sv
`timescale 1ns / 1ps
package clns_pkg;

	localparam logic [2:0] REQ_CMD    = 3'd0;
	localparam logic [2:0] REQ_CHAR   = 3'd1;
	localparam logic [2:0] REQ_CURSOR = 3'd2;
	localparam logic [2:0] REQ_NUMBER = 3'd3;
	localparam logic [2:0] REQ_INIT   = 3'd4;

	localparam logic [7:0] ROW1_BASE  = 8'hC0;
	localparam logic [7:0] ROW0_BASE  = 8'h80;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam logic [15:0] LOW_WAIT_RESET  = 16'd500;
	localparam logic [15:0] HIGH_WAIT_RESET = 16'd1500;

	localparam logic CFG_LOW_WAIT  = 1'b0;
	localparam logic CFG_HIGH_WAIT = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	// one queued job: up to three bytes, or the whole init sequence
	typedef struct packed {
		logic            init;
		logic            lcd;
		logic            rs;
		logic [1:0]      nbytes;
		logic [3:0][7:0] bytes;
	} job_t;

	// one pin step on the output
	typedef struct packed {
		logic        target_lcd;
		logic        reg_select;
		logic        read_write;
		logic        enable_level;
		logic [3:0]  data_nibble;
		logic [15:0] wait_us;
		logic        last;
	} step_t;

	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h33;
			2'd1: b = 8'h32;
			2'd2: b = 8'h28;
			2'd3: b = 8'h0C;
			default: b = 8'h0C;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// Character display sequencer, 4-bit bus. Each accepted request becomes a
// list of pin steps, one step per output transfer, the final one flagged
// with last. A byte costs four steps (high nibble, then low nibble, each
// as enable low then enable high). The back end loads a job from the queue
// and then emits its steps: four for a command, character or cursor
// request, four to twelve for a decimal number, and for initialization
// of two displays an enable-high pre step and four bytes (17 steps per
// display). The output register emits at most one step per cycle, and that
// sets the rate; a two-entry job queue lets requests be taken while an
// earlier one is still going out. Unknown request kinds and out-of-range
// displays are taken and produce no steps. Wait registers may only be
// written while idle.
module char_lcd_nibble_write_sequencer #(
	parameter int LCD_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  value,
	input  logic [2:0]  row,
	input  logic [5:0]  col,
	input  logic        lcd_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        target_lcd,
	output logic        reg_select,
	output logic        read_write,
	output logic        enable_level,
	output logic [3:0]  data_nibble,
	output logic [15:0] wait_us,
	output logic        last
);
	import clns_pkg::*;

	logic [15:0] low_wait_q;
	logic [15:0] high_wait_q;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	job_t        push_job;
	job_t        head_job;
	step_t       step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_wait_q  <= LOW_WAIT_RESET;
			high_wait_q <= HIGH_WAIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_WAIT:  low_wait_q  <= cfg_data;
				CFG_HIGH_WAIT: high_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	clns_front #(
		.LCD_COUNT(LCD_COUNT)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.value    (value),
		.row      (row),
		.col      (col),
		.lcd_id   (lcd_id),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	clns_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	clns_back #(
		.LCD_COUNT(LCD_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.low_wait  (low_wait_q),
		.high_wait (high_wait_q),
		.q_empty   (q_empty),
		.q_head    (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_step  (step)
	);

	assign target_lcd   = step.target_lcd;
	assign reg_select   = step.reg_select;
	assign read_write   = step.read_write;
	assign enable_level = step.enable_level;
	assign data_nibble  = step.data_nibble;
	assign wait_us      = step.wait_us;
	assign last         = step.last;

`include "char_lcd_nibble_write_sequencer_assert.svh"

	// a job is never pushed into a full queue
	`CLNS_ASSERT_IMP(a_no_push_full, clk, arst_n, q_push, !q_full)
	// every request ends on an enable-high step
	`CLNS_ASSERT_IMP(a_last_en_high, clk, arst_n, out_valid && last, enable_level)
	// enable-low steps carry the configured low wait
	`CLNS_ASSERT_IMP(a_low_wait, clk, arst_n, out_valid && !enable_level, wait_us == low_wait_q)

endmodule

// File: rtl/clns_front.sv
`timescale 1ns / 1ps
module clns_front #(
	parameter int LCD_COUNT = 2
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [7:0]        value,
	input  logic [2:0]        row,
	input  logic [5:0]        col,
	input  logic              lcd_id,
	input  logic              q_full,
	output logic              q_push,
	output clns_pkg::job_t    q_job
);
	import clns_pkg::*;

	logic        job_ok;
	logic        lcd_ok;
	logic [1:0]  hund;
	logic [7:0]  rem8;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [7:0]  units8;
	logic [7:0]  pos;

	assign lcd_ok = 32'(lcd_id) < LCD_COUNT;

	// binary to decimal: hundreds by compare, tens by reciprocal of ten (x205 >> 11)
	always_comb begin
		if (value >= 8'd200) begin
			hund = 2'd2;
			rem8 = value - 8'd200;
		end else if (value >= 8'd100) begin
			hund = 2'd1;
			rem8 = value - 8'd100;
		end else begin
			hund = 2'd0;
			rem8 = value;
		end
	end

	assign prod   = 15'(rem8[6:0]) * 15'd205;
	assign tens   = prod[14:11];
	assign units8 = rem8 - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};

	always_comb begin
		priority if (row == 3'd1) begin
			pos = ROW1_BASE + {2'b00, col};
		end else if (row == 3'd0 || row == 3'd2 || row == 3'd3) begin
			pos = ROW0_BASE + {2'b00, col};
		end else begin
			pos = ROW0_BASE;
		end
	end

	always_comb begin
		q_job        = '0;
		q_job.lcd    = lcd_id;
		q_job.nbytes = 2'd1;
		job_ok       = lcd_ok;
		unique case (req_type)
			REQ_CMD: begin
				q_job.bytes[0] = value;
			end
			REQ_CHAR: begin
				q_job.rs       = 1'b1;
				q_job.bytes[0] = value;
			end
			REQ_CURSOR: begin
				q_job.bytes[0] = pos;
			end
			REQ_NUMBER: begin
				q_job.rs = 1'b1;
				if (hund != 2'd0) begin
					q_job.nbytes   = 2'd3;
					q_job.bytes[0] = ASCII_ZERO + {6'd0, hund};
					q_job.bytes[1] = ASCII_ZERO + {4'd0, tens};
					q_job.bytes[2] = ASCII_ZERO + {4'd0, units8[3:0]};
				end else if (tens != 4'd0) begin
					q_job.nbytes   = 2'd2;
					q_job.bytes[0] = ASCII_ZERO + {4'd0, tens};
					q_job.bytes[1] = ASCII_ZERO + {4'd0, units8[3:0]};
				end else begin
					q_job.bytes[0] = ASCII_ZERO + {4'd0, units8[3:0]};
				end
			end
			REQ_INIT: begin
				q_job.init = 1'b1;
				q_job.lcd  = 1'b0;
				job_ok     = 1'b1;
			end
			default: begin
				job_ok = 1'b0;
			end
		endcase
	end

	// requests that produce nothing are taken and dropped
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready && job_ok;

endmodule

// File: rtl/clns_queue.sv
`timescale 1ns / 1ps
module clns_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clns_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output clns_pkg::job_t head_job,
	output logic           empty
);
	import clns_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_FULL;
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/clns_back.sv
`timescale 1ns / 1ps
module clns_back #(
	parameter int LCD_COUNT = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     low_wait,
	input  logic [15:0]     high_wait,
	input  logic            q_empty,
	input  clns_pkg::job_t  q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output clns_pkg::step_t out_step
);
	import clns_pkg::*;

	// init covers at most two displays (target is one bit)
	localparam int   INIT_DISPLAYS = (LCD_COUNT < 2) ? LCD_COUNT : 2;
	localparam logic LAST_DISP     = 1'(INIT_DISPLAYS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PRE  = 3'b010,
		ST_BYTE = 3'b100
	} state_t;

	state_t     state_q;
	job_t       job_q;
	logic [1:0] byte_q;
	logic [1:0] phase_q;   // [1] low nibble, [0] enable high
	logic       disp_q;
	logic       out_valid_q;
	step_t      step_q;

	logic       slot_free;
	logic       emit_step;
	logic [7:0] cur_byte;
	logic       end_of_byte;
	logic       last_byte;
	logic       last_step;
	step_t      byte_step;

	assign slot_free = !out_valid_q || out_ready;
	assign emit_step = slot_free && (state_q == ST_PRE || state_q == ST_BYTE);
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;

	assign cur_byte    = job_q.init ? init_byte(byte_q) : job_q.bytes[byte_q];
	assign end_of_byte = phase_q == 2'd3;
	assign last_byte   = job_q.init ? (byte_q == 2'd3) : (byte_q == job_q.nbytes - 2'd1);
	assign last_step   = end_of_byte && last_byte && (!job_q.init || disp_q == LAST_DISP);

	always_comb begin
		byte_step.target_lcd   = job_q.init ? disp_q : job_q.lcd;
		byte_step.reg_select   = job_q.init ? 1'b0 : job_q.rs;
		byte_step.read_write   = 1'b0;
		byte_step.enable_level = phase_q[0];
		byte_step.data_nibble  = phase_q[1] ? cur_byte[3:0] : cur_byte[7:4];
		byte_step.wait_us      = phase_q[0] ? high_wait : low_wait;
		byte_step.last         = last_step;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (slot_free) begin
			if (state_q == ST_PRE) begin
				step_q.target_lcd   <= disp_q;
				step_q.reg_select   <= 1'b0;
				step_q.read_write   <= 1'b0;
				step_q.enable_level <= 1'b1;
				step_q.data_nibble  <= 4'd0;
				step_q.wait_us      <= 16'd0;
				step_q.last         <= 1'b0;
			end else if (state_q == ST_BYTE) begin
				step_q <= byte_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_q      <= '0;
			phase_q     <= '0;
			disp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						byte_q  <= '0;
						phase_q <= '0;
						disp_q  <= 1'b0;
						state_q <= q_head.init ? ST_PRE : ST_BYTE;
					end
				end
				ST_PRE: begin
					if (slot_free) begin
						byte_q      <= '0;
						phase_q     <= '0;
						state_q     <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (slot_free) begin
						if (last_step) begin
							state_q <= ST_IDLE;
						end else if (end_of_byte && last_byte) begin
							// next display of an init job
							disp_q  <= disp_q + 1'b1;
							state_q <= ST_PRE;
						end else if (end_of_byte) begin
							byte_q  <= byte_q + 2'd1;
							phase_q <= '0;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_step  = step_q;

endmodule
